FILE: sv/vfc_pkg.sv
// Shared constants and the byte-wise CRC-16 update for the velocity frame encoder.
package vfc_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned IdxW     = 4;

  // Fixed frame bytes
  localparam logic [7:0] SyncA     = 8'hAA;
  localparam logic [7:0] SyncB     = 8'h55;
  localparam logic [7:0] Trailer   = 8'hDD;
  localparam logic [7:0] CodeReset = 8'h60;

  // CRC-16, reflected form
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Byte positions within the frame
  localparam logic [IdxW-1:0] IdxSyncA  = 4'd0;
  localparam logic [IdxW-1:0] IdxSyncB  = 4'd1;
  localparam logic [IdxW-1:0] IdxCode   = 4'd2;
  localparam logic [IdxW-1:0] IdxLinHi  = 4'd3;
  localparam logic [IdxW-1:0] IdxLinLo  = 4'd4;
  localparam logic [IdxW-1:0] IdxAngHi  = 4'd5;
  localparam logic [IdxW-1:0] IdxAngLo  = 4'd6;
  localparam logic [IdxW-1:0] IdxCrcHi  = 4'd7;
  localparam logic [IdxW-1:0] IdxCrcLo  = 4'd8;
  localparam logic [IdxW-1:0] IdxTrail  = 4'd9;

  // Fold one byte into the running CRC, one bit per step, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

FILE: sv/velocity_frame_crc16_encoder.sv
// Velocity command frame encoder: ten-byte frame with a reflected CRC-16 per input transfer.
// The input transfer fills the buffer, the sequencer then takes the item, and the output
// register carries each byte; the ten bytes follow at one per cycle when the sink is ready.
// A new input item can be buffered while the previous frame is still being sent.
// The CRC is folded one byte per cycle as bytes 0 to 6 are loaded into the output register.
// Reset clears all valid flags and sets the command code to 0x60.
module velocity_frame_crc16_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] linear_velocity_i,
  input  logic signed [15:0] angular_velocity_i,
  input  logic               cfg_we_i,
  input  logic        [7:0]  cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [7:0]  frame_byte_o,
  output logic               last_of_frame_o
);
  import vfc_pkg::*;

  logic [7:0]      code_q;
  logic            buf_valid_q, buf_valid_d;
  logic [15:0]     buf_lin_q, buf_ang_q;
  logic            act_q, act_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     lin_q, ang_q;
  logic [15:0]     crc_q, crc_d;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            in_xfer;
  logic            load_out;
  logic            emit;
  logic            frame_end;
  logic            start;
  logic [7:0]      cur_byte;

  assign in_ready_o      = ~buf_valid_q;
  assign in_xfer         = in_valid_i & in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign last_of_frame_o = out_last_q;

  // Output register takes a new byte when empty or when its byte leaves
  assign load_out  = ~out_valid_q | out_ready_i;
  assign emit      = act_q & load_out;
  assign frame_end = emit & (idx_q == IdxTrail);
  assign start     = buf_valid_q & (~act_q | frame_end);

  // Select the current frame byte
  always_comb begin
    unique case (idx_q)
      IdxSyncA: cur_byte = SyncA;
      IdxSyncB: cur_byte = SyncB;
      IdxCode:  cur_byte = code_q;
      IdxLinHi: cur_byte = lin_q[15:8];
      IdxLinLo: cur_byte = lin_q[7:0];
      IdxAngHi: cur_byte = ang_q[15:8];
      IdxAngLo: cur_byte = ang_q[7:0];
      IdxCrcHi: cur_byte = crc_q[15:8];
      IdxCrcLo: cur_byte = crc_q[7:0];
      IdxTrail: cur_byte = Trailer;
      default:  cur_byte = 8'h00;
    endcase
  end

  // Advance the frame sequencer and the running CRC
  always_comb begin
    act_d       = act_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    buf_valid_d = buf_valid_q;
    if (emit) begin
      idx_d = idx_q + 1'b1;
      if (idx_q < IdxCrcHi) begin
        crc_d = crc16_byte(crc_q, cur_byte);
      end
      if (frame_end) begin
        act_d = 1'b0;
      end
    end
    if (start) begin
      act_d       = 1'b1;
      idx_d       = IdxSyncA;
      crc_d       = CrcInit;
      buf_valid_d = 1'b0;
    end
    if (in_xfer) begin
      buf_valid_d = 1'b1;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= CodeReset;
      buf_valid_q <= 1'b0;
      act_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        code_q <= cfg_wdata_i;
      end
      buf_valid_q <= buf_valid_d;
      act_q       <= act_d;
      idx_q       <= idx_d;
      if (load_out) begin
        out_valid_q <= act_q;
      end
    end
  end

  // Payload registers: input buffer, frame values, CRC and output byte
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_lin_q <= linear_velocity_i;
      buf_ang_q <= angular_velocity_i;
    end
    if (start) begin
      lin_q <= buf_lin_q;
      ang_q <= buf_ang_q;
    end
    crc_q <= crc_d;
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= (idx_q == IdxTrail);
    end
  end

endmodule

FILE: bench/velocity_frame_crc16_encoder_test.sv
// Self-checking testbench for the velocity frame encoder with MODBUS CRC-16.
`timescale 1ns / 1ps

module velocity_frame_crc16_encoder_test;
  import vfc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned MaxReports  = 10;

  // One expected output byte with its end-of-frame flag
  typedef struct {
    logic [7:0] octet;
    logic       last;
  } frame_octet_t;

  // One directed row: optional code write ahead of it, payload, optional typed-in head
  typedef struct packed {
    logic        set_code;
    logic [7:0]  code;
    logic [15:0] lin;
    logic [15:0] ang;
    logic        known;
    logic [55:0] head;
  } directed_row_t;

  localparam int unsigned DirectedRows = 14;
  localparam directed_row_t Directed [DirectedRows] = '{
    // values after reset and field extremes, head bytes read straight off the payload
    '{1'b0, 8'h00, 16'h0000, 16'h0000, 1'b1, 56'hAA_55_60_00_00_00_00},
    '{1'b0, 8'h00, 16'h7FFF, 16'h7FFF, 1'b1, 56'hAA_55_60_7F_FF_7F_FF},
    '{1'b0, 8'h00, 16'h8000, 16'h8000, 1'b1, 56'hAA_55_60_80_00_80_00},
    '{1'b0, 8'h00, 16'hFFFF, 16'h0000, 1'b1, 56'hAA_55_60_FF_FF_00_00},
    '{1'b0, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 56'hAA_55_60_00_00_FF_FF},
    '{1'b0, 8'h00, 16'h7FFF, 16'h8000, 1'b1, 56'hAA_55_60_7F_FF_80_00},
    '{1'b0, 8'h00, 16'h8000, 16'h7FFF, 1'b1, 56'hAA_55_60_80_00_7F_FF},
    '{1'b0, 8'h00, 16'h0001, 16'hFFFE, 1'b0, 56'h0},
    '{1'b0, 8'h00, 16'h1234, 16'hABCD, 1'b0, 56'h0},
    // command code extremes
    '{1'b1, 8'h00, 16'h5555, 16'hAAAA, 1'b1, 56'hAA_55_00_55_55_AA_AA},
    '{1'b1, 8'hFF, 16'hAAAA, 16'h5555, 1'b1, 56'hAA_55_FF_AA_AA_55_55},
    '{1'b0, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1, 56'hAA_55_FF_FF_FF_FF_FF},
    '{1'b1, 8'h01, 16'h0000, 16'h0000, 1'b0, 56'h0},
    '{1'b1, 8'h80, 16'hC3A5, 16'h3C5A, 1'b0, 56'h0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] linear_velocity_i;
  logic signed [15:0] angular_velocity_i;
  logic               cfg_we_i;
  logic        [7:0]  cfg_wdata_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic        [7:0]  frame_byte_o;
  logic               last_of_frame_o;

  frame_octet_t expected_octets [$];
  logic [7:0]   code_shadow;
  logic         no_stall;
  int unsigned  mismatches;
  int unsigned  cycle_count;

  velocity_frame_crc16_encoder DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .linear_velocity_i  (linear_velocity_i),
    .angular_velocity_i (angular_velocity_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_byte_o       (frame_byte_o),
    .last_of_frame_o    (last_of_frame_o)
  );

  // Generate the 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run length
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reflected CRC-16 over the seven head bytes, most significant byte first in the vector
  function automatic logic [15:0] modbus_crc(input logic [55:0] head);
    logic [15:0] acc;
    acc = CrcInit;
    for (int n = 6; n >= 0; n--) begin
      acc = acc ^ {8'h00, head[n*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Append the ten bytes a head expands to
  task automatic queue_frame(input logic [55:0] head);
    logic [79:0]  frame;
    frame_octet_t item;
    frame = {head, modbus_crc(head), Trailer};
    for (int k = 0; k < FrameLen; k++) begin
      item.octet = frame[79 - 8*k -: 8];
      item.last  = (k == FrameLen - 1);
      expected_octets.push_back(item);
    end
  endtask

  function automatic int draw_gap();
    return no_stall ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic note_mismatch(input string what, input logic [8:0] want, input logic [8:0] got);
    if (mismatches < MaxReports) begin
      $display("mismatch %s: expected byte %h last %b, got byte %h last %b",
               what, want[8:1], want[0], got[8:1], got[0]);
    end
    mismatches++;
  endtask

  // Present one velocity pair after a random gap, hold until the transfer
  task automatic send_velocity(input logic [15:0] lin, input logic [15:0] ang,
                               input logic [55:0] head);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    linear_velocity_i  = lin;
    angular_velocity_i = ang;
    do @(posedge clk_i); while (!in_ready_o);
    queue_frame(head);
  endtask

  // Drop valid and let every expected byte drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_octets.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the command code register; caller is at a falling edge with the block idle
  task automatic write_code(input logic [7:0] code);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = code;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    code_shadow = code;
  endtask

  // Sink: random ready gaps, check each output transfer against the oldest expectation
  initial begin
    frame_octet_t want;
    int           gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_octets.size() == 0) begin
        note_mismatch("unexpected byte", 9'h0, {frame_byte_o, last_of_frame_o});
      end else begin
        want = expected_octets.pop_front();
        if (want.octet !== frame_byte_o || want.last !== last_of_frame_o) begin
          note_mismatch("frame byte", {want.octet, want.last},
                        {frame_byte_o, last_of_frame_o});
        end
      end
    end
  end

  // Source: directed table, then random phases with code changes between them
  initial begin
    logic [15:0] lin;
    logic [15:0] ang;
    logic [55:0] head;
    logic [7:0]  code;
    int unsigned sent;

    mismatches         = 0;
    code_shadow        = CodeReset;
    no_stall           = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    linear_velocity_i  = '0;
    angular_velocity_i = '0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    for (int r = 0; r < DirectedRows; r++) begin
      if (Directed[r].set_code) begin
        wait_idle();
        write_code(Directed[r].code);
      end
      head = Directed[r].known ? Directed[r].head
                               : {SyncA, SyncB, code_shadow, Directed[r].lin, Directed[r].ang};
      send_velocity(Directed[r].lin, Directed[r].ang, head);
    end

    // Random phases; the code changes only while the block is drained
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      case ((sent / PhaseItems) % 4)
        0:       code = 8'h00;
        1:       code = 8'hFF;
        default: code = 8'($urandom_range(0, 255));
      endcase
      write_code(code);
      no_stall = ((sent / PhaseItems) % 3 == 1);
      for (int i = 0; i < PhaseItems && sent < RandomItems; i++) begin
        // hold off now and then until every frame is out
        if ($urandom_range(0, 39) == 0) wait_idle();
        case ($urandom_range(0, 7))
          0:       lin = 16'h8000;
          1:       lin = 16'h7FFF;
          2:       lin = 16'hFFFF;
          default: lin = 16'($urandom());
        endcase
        case ($urandom_range(0, 7))
          0:       ang = 16'h8000;
          1:       ang = 16'h0000;
          2:       ang = 16'hFFFF;
          default: ang = 16'($urandom());
        endcase
        send_velocity(lin, ang, {SyncA, SyncB, code_shadow, lin, ang});
        sent++;
      end
    end

    // Drain and settle
    @(negedge clk_i);
    in_valid_i = 1'b0;
    no_stall   = 1'b0;
    while (expected_octets.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (expected_octets.size() != 0) mismatches += expected_octets.size();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/vfc_pkg.sv
sv/velocity_frame_crc16_encoder.sv
bench/velocity_frame_crc16_encoder_test.sv
